// ===== rtl/errc_pkg.sv =====
package errc_pkg;

	localparam int MEM_DEPTH_DEF = 65536;

	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_READ    = 2'd1;
	localparam logic [1:0] CMD_EXEC    = 2'd2;
	localparam logic [1:0] CMD_RESTART = 2'd3;

	localparam logic [4:0] OP_ADD = 5'd0;
	localparam logic [4:0] OP_SUB = 5'd1;
	localparam logic [4:0] OP_LSF = 5'd2;
	localparam logic [4:0] OP_RSF = 5'd3;
	localparam logic [4:0] OP_AND = 5'd4;
	localparam logic [4:0] OP_OR  = 5'd5;
	localparam logic [4:0] OP_XOR = 5'd6;
	localparam logic [4:0] OP_LHI = 5'd7;
	localparam logic [4:0] OP_LD  = 5'd8;
	localparam logic [4:0] OP_ST  = 5'd9;
	localparam logic [4:0] OP_JLT = 5'd16;
	localparam logic [4:0] OP_JLE = 5'd17;
	localparam logic [4:0] OP_JEQ = 5'd18;
	localparam logic [4:0] OP_JNE = 5'd19;
	localparam logic [4:0] OP_JIN = 5'd20;
	localparam logic [4:0] OP_HLT = 5'd24;

	// datapath memory port selection
	typedef enum logic [1:0] {
		MA_CMD  = 2'd0,
		MA_PC   = 2'd1,
		MA_ALU1 = 2'd2
	} maddr_sel_t;

	typedef struct packed {
		logic       take_in;
		maddr_sel_t maddr_sel;
		logic       mem_rd;
		logic       mem_wr_cmd;
		logic       mem_wr_st;
		logic       latch_inst;
		logic       latch_ops;
		logic       exec;
		logic       wb_load;
		logic       restart;
		logic       set_res;
	} errc_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       halted;
		logic [4:0] opcode;
	} errc_stat_t;

endpackage

// ===== rtl/errc_datapath.sv =====
module errc_datapath import errc_pkg::*; #(
	parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  errc_cmd_t   ctl,
	output errc_stat_t  stat,
	input  logic [1:0]  in_cmd,
	input  logic [15:0] in_addr,
	input  logic [31:0] in_data,
	output logic [31:0] read_word,
	output logic [15:0] pc_after,
	output logic        halted,
	output logic [4:0]  executed_opcode
);
	localparam int AW = $clog2(MEM_DEPTH);

	logic [31:0] mem [MEM_DEPTH];
	logic [31:0] rdata_q;
	logic [1:0]  cmd_q;
	logic [15:0] addr_q;
	logic [31:0] data_q;
	logic [31:0] inst_q;
	logic [31:0] regs_q [2:7];
	logic [31:0] a0_q, a1_q;
	logic [15:0] pc_q;
	logic        halt_q;
	logic [31:0] res_rd_q;
	logic [4:0]  res_op_q;

	logic [4:0]  op;
	logic [2:0]  dst, s0, s1;
	logic [31:0] imm, alu, dst_old;
	logic [4:0]  sh;
	logic        take, wr;
	logic [AW-1:0] maddr;

	assign op  = inst_q[29:25];
	assign dst = inst_q[24:22];
	assign s0  = inst_q[21:19];
	assign s1  = inst_q[18:16];
	assign imm = {{16{inst_q[15]}}, inst_q[15:0]};
	assign sh  = a1_q[4:0];

	function automatic logic [31:0] rd_op(input logic [2:0] i, input logic [31:0] im,
			input logic [31:0] r2, input logic [31:0] r3, input logic [31:0] r4,
			input logic [31:0] r5, input logic [31:0] r6, input logic [31:0] r7);
		case (i)
			3'd0: rd_op = '0;
			3'd1: rd_op = im;
			3'd2: rd_op = r2;
			3'd3: rd_op = r3;
			3'd4: rd_op = r4;
			3'd5: rd_op = r5;
			3'd6: rd_op = r6;
			default: rd_op = r7;
		endcase
	endfunction

	assign dst_old = rd_op(dst, imm, regs_q[2], regs_q[3], regs_q[4], regs_q[5],
		regs_q[6], regs_q[7]);

	always_comb begin
		alu = '0;
		wr = 1'b0;
		take = 1'b0;
		case (op)
			OP_ADD: begin alu = a0_q + a1_q; wr = 1'b1; end
			OP_SUB: begin alu = a0_q - a1_q; wr = 1'b1; end
			OP_LSF: begin alu = a0_q << sh; wr = 1'b1; end
			OP_RSF: begin alu = $unsigned($signed(a0_q) >>> sh); wr = 1'b1; end
			OP_AND: begin alu = a0_q & a1_q; wr = 1'b1; end
			OP_OR:  begin alu = a0_q | a1_q; wr = 1'b1; end
			OP_XOR: begin alu = a0_q ^ a1_q; wr = 1'b1; end
			OP_LHI: begin alu = {inst_q[15:0], dst_old[15:0]}; wr = 1'b1; end
			OP_JLT: take = $signed(a0_q) < $signed(a1_q);
			OP_JLE: take = $signed(a0_q) <= $signed(a1_q);
			OP_JEQ: take = a0_q == a1_q;
			OP_JNE: take = a0_q != a1_q;
			OP_JIN: take = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		case (ctl.maddr_sel)
			MA_PC:   maddr = pc_q[AW-1:0];
			MA_ALU1: maddr = a1_q[AW-1:0];
			default: maddr = addr_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.mem_wr_cmd)
			mem[maddr] <= data_q;
		else if (ctl.mem_wr_st)
			mem[maddr] <= a0_q;
		if (ctl.mem_rd)
			rdata_q <= mem[maddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.take_in) begin
			cmd_q  <= in_cmd;
			addr_q <= in_addr;
			data_q <= in_data;
		end
		if (ctl.latch_inst)
			inst_q <= rdata_q;
		if (ctl.latch_ops) begin
			a0_q <= rd_op(s0, imm, regs_q[2], regs_q[3], regs_q[4], regs_q[5],
				regs_q[6], regs_q[7]);
			a1_q <= rd_op(s1, imm, regs_q[2], regs_q[3], regs_q[4], regs_q[5],
				regs_q[6], regs_q[7]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 2; i < 8; i++)
				regs_q[i] <= '0;
			pc_q     <= '0;
			halt_q   <= 1'b0;
			res_rd_q <= '0;
			res_op_q <= '0;
		end else begin
			if (ctl.exec) begin
				if (wr && dst >= 3'd2)
					regs_q[dst] <= alu;
				if (op == OP_HLT)
					halt_q <= 1'b1;
				else if (take) begin
					regs_q[7] <= {16'd0, pc_q};
					pc_q <= inst_q[15:0];
				end else
					pc_q <= pc_q + 16'd1;
			end
			if (ctl.wb_load && dst >= 3'd2)
				regs_q[dst] <= rdata_q;
			if (ctl.restart) begin
				pc_q   <= '0;
				halt_q <= 1'b0;
			end
			if (ctl.set_res) begin
				res_rd_q <= (cmd_q == CMD_READ) ? rdata_q : '0;
				res_op_q <= (cmd_q == CMD_EXEC && !halt_q) ? op : '0;
			end
		end
	end

	assign stat.cmd    = cmd_q;
	assign stat.halted = halt_q;
	assign stat.opcode = op;

	assign read_word       = res_rd_q;
	assign pc_after        = pc_q;
	assign halted          = halt_q;
	assign executed_opcode = res_op_q;
endmodule

// ===== rtl/errc_ctrl.sv =====
module errc_ctrl import errc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  errc_stat_t stat,
	output errc_cmd_t  ctl
);
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DISP   = 7'b0000010,
		S_FETCH  = 7'b0000100,
		S_DEC    = 7'b0001000,
		S_OPS    = 7'b0010000,
		S_EXEC   = 7'b0100000,
		S_LDWB   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_q, done;

	assign s_tready = (state_q == S_IDLE) && (!out_q || m_tready);
	assign m_tvalid = out_q;

	always_comb begin
		ctl = '0;
		ctl.maddr_sel = MA_CMD;
		ctl.take_in = s_tvalid && s_tready;
		state_d = state_q;
		done = 1'b0;
		case (state_q)
			S_IDLE: if (ctl.take_in) state_d = S_DISP;
			S_DISP: begin
				case (stat.cmd)
					CMD_LOAD: begin ctl.mem_wr_cmd = 1'b1; done = 1'b1; end
					CMD_READ: begin ctl.mem_rd = 1'b1; state_d = S_LDWB; end
					CMD_EXEC: begin
						if (stat.halted) done = 1'b1;
						else begin
							ctl.maddr_sel = MA_PC;
							ctl.mem_rd = 1'b1;
							state_d = S_FETCH;
						end
					end
					default: begin ctl.restart = 1'b1; done = 1'b1; end
				endcase
			end
			S_FETCH: begin ctl.latch_inst = 1'b1; state_d = S_DEC; end
			S_DEC:   begin ctl.latch_ops = 1'b1; state_d = S_OPS; end
			S_OPS: begin
				ctl.maddr_sel = MA_ALU1;
				if (stat.opcode == OP_LD) ctl.mem_rd = 1'b1;
				if (stat.opcode == OP_ST) ctl.mem_wr_st = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				if (stat.opcode == OP_LD) ctl.wb_load = 1'b1;
				done = 1'b1;
			end
			S_LDWB: done = 1'b1;
			default: state_d = S_IDLE;
		endcase
		if (done) begin
			ctl.set_res = 1'b1;
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done)
				out_q <= 1'b1;
			else if (m_tready)
				out_q <= 1'b0;
		end
	end
endmodule

// ===== rtl/eight_register_risc_core.sv =====
// Multicycle core with a word memory. Each slave transaction is one command (load word, read
// word, execute one instruction, restart) and yields exactly one master transaction. Load and
// restart and halted execute end in dispatch, read in S_LDWB; an instruction steps through
// accept, dispatch with the fetch read, instruction latch, decode with operand read,
// memory access and execute, all set by the single memory port and the controller sequence.
// A waiting result blocks the next command; the next command is accepted at the earliest in
// the cycle the waiting result is taken. Memory contents are undefined until written.
module eight_register_risc_core import errc_pkg::*; #(
	parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // cmd[1:0], mem_addr[17:2], mem_data[49:18], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // read_word[31:0], pc_after[47:32], halted[48], opcode[53:49]
);
	errc_cmd_t   ctl;
	errc_stat_t  stat;
	logic [31:0] read_word;
	logic [15:0] pc_after;
	logic        halted;
	logic [4:0]  executed_opcode;

	errc_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .stat, .ctl
	);

	errc_datapath #(.MEM_DEPTH(MEM_DEPTH)) u_dp (
		.clk, .arst_n, .ctl, .stat,
		.in_cmd(s_tdata[1:0]), .in_addr(s_tdata[17:2]), .in_data(s_tdata[49:18]),
		.read_word, .pc_after, .halted, .executed_opcode
	);

	assign m_tdata = {2'b00, executed_opcode, halted, pc_after, read_word};
endmodule

// ===== rtl/errc_checker.sv =====
module errc_checker import errc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted while busy");
	a_halt_noop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[48] |-> m_tdata[53:49] == 5'd0 || m_tdata[53:49] == OP_HLT)
		else $error("opcode reported while halted");
	a_no_out_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid || !$past(m_tvalid) || $stable(m_tdata)
		|| $past(m_tready))
		else $error("result lost");
endmodule

bind eight_register_risc_core errc_checker u_chk (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

// ===== dv/testbench.sv =====
module testbench import errc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [4:0]  opcode;
		logic        halted;
		logic [15:0] pc_after;
		logic [31:0] read_word;
	} core_result_t;

	class core_scoreboard;
		logic [31:0] regs [2:7];
		logic [15:0] pc;
		logic        halt;
		logic [31:0] mem [int];
		core_result_t pending [$];
		int errors;

		function new();
			for (int i = 2; i <= 7; i++) regs[i] = '0;
			pc = '0;
			halt = 1'b0;
			errors = 0;
		endfunction

		function logic [31:0] operand(logic [2:0] idx, logic [31:0] imm);
			if (idx == 3'd0) return '0;
			if (idx == 3'd1) return imm;
			return regs[idx];
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] v);
			if (idx >= 3'd2) regs[idx] = v;
		endfunction

		function logic [31:0] mem_rd(logic [15:0] a);
			return mem.exists(a) ? mem[a] : '0;
		endfunction

		function logic [4:0] run_instruction();
			logic [31:0] inst, imm, a0, a1, old;
			logic [4:0] op;
			logic [2:0] dst;
			logic [15:0] nxt;
			logic jump, take;
			inst = mem_rd(pc);
			op = inst[29:25];
			dst = inst[24:22];
			imm = {{16{inst[15]}}, inst[15:0]};
			a0 = operand(inst[21:19], imm);
			a1 = operand(inst[18:16], imm);
			nxt = pc + 16'd1;
			jump = 1'b0;
			take = 1'b0;
			case (op)
				OP_ADD: write_reg(dst, a0 + a1);
				OP_SUB: write_reg(dst, a0 - a1);
				OP_LSF: write_reg(dst, a0 << a1[4:0]);
				OP_RSF: write_reg(dst, $signed(a0) >>> a1[4:0]);
				OP_AND: write_reg(dst, a0 & a1);
				OP_OR:  write_reg(dst, a0 | a1);
				OP_XOR: write_reg(dst, a0 ^ a1);
				OP_LHI: begin
					old = operand(dst, imm);
					write_reg(dst, {imm[15:0], old[15:0]});
				end
				OP_LD:  write_reg(dst, mem_rd(a1[15:0]));
				OP_ST:  mem[a1[15:0]] = a0;
				OP_JLT: begin jump = 1'b1; take = $signed(a0) < $signed(a1); end
				OP_JLE: begin jump = 1'b1; take = $signed(a0) <= $signed(a1); end
				OP_JEQ: begin jump = 1'b1; take = a0 == a1; end
				OP_JNE: begin jump = 1'b1; take = a0 != a1; end
				OP_JIN: begin jump = 1'b1; take = 1'b1; end
				OP_HLT: begin halt = 1'b1; nxt = pc; end
				default: ;
			endcase
			if (jump && take) begin
				regs[7] = {16'd0, pc};
				nxt = imm[15:0];
			end
			pc = nxt;
			return op;
		endfunction

		function void note_command(logic [1:0] cmd, logic [15:0] addr, logic [31:0] data);
			core_result_t r;
			r = '0;
			case (cmd)
				CMD_LOAD: mem[addr] = data;
				CMD_READ: r.read_word = mem_rd(addr);
				CMD_EXEC: if (!halt) r.opcode = run_instruction();
				default: begin pc = '0; halt = 1'b0; end
			endcase
			r.pc_after = pc;
			r.halted = halt;
			pending.push_back(r);
		endfunction

		function void check_result(logic [55:0] tdata);
			core_result_t got, exp;
			got = tdata[53:0];
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp rd=%h pc=%h h=%b op=%h  got rd=%h pc=%h h=%b op=%h",
						exp.read_word, exp.pc_after, exp.halted, exp.opcode,
						got.read_word, got.pc_after, got.halted, got.opcode);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [55:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [55:0] m_tdata;

	core_scoreboard sb;
	bit long_hold = 0;
	bit [15:0] written [$];

	eight_register_risc_core dut (.*);

	always #10 clk = ~clk;

	// receiver
	initial begin
		int n;
		n = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			n++;
			if (long_hold) m_tready <= 1'b0;
			else if ((n / 64) % 3 == 0) m_tready <= 1'b1;
			else m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		#50ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic send(logic [1:0] cmd, logic [15:0] addr, logic [31:0] data);
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, data, addr, cmd};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, addr, data);
		if (cmd == CMD_LOAD) written.push_back(addr);
	endtask

	task automatic pause();
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	function automatic logic [31:0] mk_inst(logic [4:0] op, logic [2:0] d, logic [2:0] a,
			logic [2:0] b, logic [15:0] imm);
		return {2'($urandom_range(0, 3)), op, d, a, b, imm};
	endfunction

	function automatic logic [4:0] rand_op();
		logic [4:0] ops [16] = '{OP_ADD, OP_SUB, OP_LSF, OP_RSF, OP_AND, OP_OR, OP_XOR,
			OP_LHI, OP_LD, OP_ST, OP_JLT, OP_JLE, OP_JEQ, OP_JNE, OP_JIN, OP_HLT};
		if ($urandom_range(0, 15) == 0) return 5'($urandom_range(10, 31));
		return ops[$urandom_range(0, 15)];
	endfunction

	// load a program at 0..len-1 with data words at 0x100..0x10f, then run it
	task automatic program_run(int len, int steps);
		logic [4:0] op;
		logic [15:0] imm;
		int burst;
		for (int i = 0; i < 16; i++) send(CMD_LOAD, 16'(16'h100 + i), $urandom());
		for (int i = 0; i < len; i++) begin
			op = rand_op();
			imm = 16'($urandom());
			if (op inside {OP_LD, OP_ST}) imm = 16'(16'h100 + $urandom_range(0, 15));
			else if (op inside {OP_JLT, OP_JLE, OP_JEQ, OP_JNE, OP_JIN})
				imm = 16'($urandom_range(0, len - 1));
			if (op inside {OP_LD, OP_ST, OP_JLT, OP_JLE, OP_JEQ, OP_JNE, OP_JIN})
				send(CMD_LOAD, 16'(i), mk_inst(op, 3'($urandom()), 3'($urandom()), 3'd1, imm));
			else
				send(CMD_LOAD, 16'(i), mk_inst(op, 3'($urandom()), 3'($urandom()),
					3'($urandom()), imm));
		end
		send(CMD_RESTART, 16'($urandom()), $urandom());
		burst = $urandom_range(1, 12);
		for (int i = 0; i < steps; i++) begin
			// pc may run past the program by stepping off its end; keep it inside
			if (sb.pc >= len) send(CMD_RESTART, 16'($urandom()), $urandom());
			else send(CMD_EXEC, 16'($urandom()), $urandom());
			if (--burst == 0) begin
				pause();
				burst = $urandom_range(1, 12);
			end
		end
		repeat ($urandom_range(0, 3)) send(CMD_READ, written[$urandom_range(0, written.size() - 1)],
			$urandom());
	endtask

	initial begin
		int cnt;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes and a sample of operations
		send(CMD_LOAD, 16'hffff, 32'hffff_ffff);
		send(CMD_READ, 16'hffff, 32'h0);
		send(CMD_LOAD, 16'h0000, {2'b11, OP_LHI, 3'd2, 3'd0, 3'd0, 16'h8001});
		send(CMD_LOAD, 16'h0001, {2'b00, OP_RSF, 3'd3, 3'd2, 3'd1, 16'h001f});
		send(CMD_LOAD, 16'h0002, {2'b00, OP_LHI, 3'd1, 3'd0, 3'd0, 16'h1234});
		send(CMD_LOAD, 16'h0003, {2'b00, OP_ADD, 3'd0, 3'd1, 3'd1, 16'h7fff});
		send(CMD_LOAD, 16'h0004, {2'b00, OP_ST, 3'd0, 3'd2, 3'd1, 16'hffff});
		send(CMD_LOAD, 16'h0005, {2'b00, OP_JLT, 3'd0, 3'd2, 3'd0, 16'h0007});
		send(CMD_LOAD, 16'h0007, {2'b00, OP_XOR, 3'd4, 3'd2, 3'd1, 16'h8000});
		send(CMD_LOAD, 16'h0008, {2'b00, OP_LD, 3'd5, 3'd0, 3'd1, 16'hffff});
		send(CMD_LOAD, 16'h0009, {2'b00, OP_HLT, 3'd0, 3'd0, 3'd0, 16'h0000});
		for (int i = 0; i < 9; i++) send(CMD_EXEC, 16'h0, 32'h0);
		send(CMD_READ, 16'hffff, 32'h0);
		send(CMD_RESTART, 16'hffff, 32'hffff_ffff);
		pause();
		// long receiver hold while sending
		fork
			begin
				long_hold = 1;
				repeat (200) @(posedge clk);
				long_hold = 0;
			end
			for (int i = 0; i < 12; i++) send(CMD_READ, 16'hffff, $urandom());
		join
		// random programs
		cnt = 0;
		while (cnt < 420) begin
			int len, steps;
			len = $urandom_range(4, 20);
			steps = $urandom_range(10, 40);
			program_run(len, steps);
			cnt += len + steps + 17;
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 4)) send($urandom_range(0, 3) == 0 ? CMD_RESTART : CMD_LOAD,
					16'($urandom_range(16'h200, 16'hffff)), $urandom());
		end
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
